[design/art_pkg.sv]
// Shared types, constants and GF(2^8) table builders for the AES round transforms.
package art_pkg;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] state_t;
  typedef byte_t [3:0] column_t;
  typedef byte_t sbox_t [256];

  typedef enum logic [1:0] {
    MODE_SUB     = 2'd0,
    MODE_INV_SUB = 2'd1,
    MODE_SHIFT   = 2'd2,
    MODE_MIX     = 2'd3
  } mode_e;

  localparam byte_t POLY_LOW = 8'h1B;
  localparam byte_t AFF_FWD  = 8'h63;
  localparam byte_t AFF_INV  = 8'h05;

  function automatic byte_t xtime(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t acc;
    byte_t x;
    byte_t y;
    acc = 8'h00;
    x   = a;
    y   = b;
    for (int i = 0; i < 8; i++) begin
      if (y[0]) begin
        acc = acc ^ x;
      end
      y = {1'b0, y[7:1]};
      x = xtime(x);
    end
    return acc;
  endfunction

  // The field inverse is x^254; zero maps to zero.
  function automatic byte_t gf_inv(byte_t x);
    byte_t x2;
    byte_t x3;
    byte_t x12;
    byte_t x15;
    byte_t p;
    x2  = gf_mul(x, x);
    x3  = gf_mul(x2, x);
    x12 = gf_mul(gf_mul(x3, x3), gf_mul(x3, x3));
    x15 = gf_mul(x12, x3);
    p   = gf_mul(x15, x15);
    p   = gf_mul(p, p);
    p   = gf_mul(p, p);
    p   = gf_mul(p, p);
    p   = gf_mul(p, x12);
    return gf_mul(p, x2);
  endfunction

  function automatic byte_t rotl8(byte_t v, int n);
    return byte_t'({v, v} >> (8 - n));
  endfunction

  function automatic sbox_t build_fwd();
    sbox_t t;
    byte_t b;
    for (int i = 0; i < 256; i++) begin
      b    = gf_inv(byte_t'(i));
      t[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ AFF_FWD;
    end
    return t;
  endfunction

  function automatic sbox_t build_inv();
    sbox_t t;
    byte_t s;
    for (int i = 0; i < 256; i++) begin
      s    = byte_t'(i);
      t[i] = gf_inv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ AFF_INV);
    end
    return t;
  endfunction

  localparam sbox_t SBOX_FWD = build_fwd();
  localparam sbox_t SBOX_INV = build_inv();

endpackage

[design/aes_round_transforms.sv]
// Top level: three-stage pipeline applying one AES round transform to a 16-byte state.
// Each accepted item passes through the stage-one, stage-two and output registers in order.
// Throughput: one item per cycle; busy_o is held low because no stage ever stalls.
// Stage one registers the input, stage two does the S-box lookups, ShiftRows and doubling,
// and stage three combines the MixColumns terms into the output register.
// Reset clears the valid bits of all three stages, so valid_o is low until an item arrives.
module aes_round_transforms (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] state_hi_i,
  input  logic [63:0] state_lo_i,
  output logic        valid_o,
  output logic [63:0] result_hi_o,
  output logic [63:0] result_lo_o
);
  import art_pkg::*;

  logic   accept;
  state_t state_in;

  logic   s1_vld_q;
  mode_e  s1_mode_q;
  state_t s1_state_q;

  state_t base_d;
  state_t dbl_d;
  logic   s2_vld_q;
  logic   s2_mix_q;
  state_t s2_base_q;
  state_t s2_dbl_q;

  state_t mixed;
  state_t res_d;
  logic   out_vld_q;
  state_t out_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      state_in[i]     = state_hi_i[63 - 8 * i -: 8];
      state_in[8 + i] = state_lo_i[63 - 8 * i -: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= accept;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q  <= mode_e'(mode_i);
      s1_state_q <= state_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      dbl_d[i] = xtime(s1_state_q[i]);
    end
    unique case (s1_mode_q)
      MODE_SUB: begin
        for (int i = 0; i < 16; i++) begin
          base_d[i] = SBOX_FWD[s1_state_q[i]];
        end
      end
      MODE_INV_SUB: begin
        for (int i = 0; i < 16; i++) begin
          base_d[i] = SBOX_INV[s1_state_q[i]];
        end
      end
      MODE_SHIFT: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            base_d[4 * r + c] = s1_state_q[4 * r + ((c + r) % 4)];
          end
        end
      end
      MODE_MIX: begin
        base_d = s1_state_q;
      end
      default: begin
        base_d = s1_state_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_mix_q  <= (s1_mode_q == MODE_MIX);
      s2_base_q <= base_d;
      s2_dbl_q  <= dbl_d;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    column_t col_a;
    column_t col_dbl;
    column_t col_res;

    for (genvar r = 0; r < 4; r++) begin : g_row
      assign col_a[r]          = s2_base_q[4 * r + c];
      assign col_dbl[r]        = s2_dbl_q[4 * r + c];
      assign mixed[4 * r + c]  = col_res[r];
    end

    art_mix_col u_mix_col (
      .a_i  (col_a),
      .dbl_i(col_dbl),
      .col_o(col_res)
    );
  end

  assign res_d = s2_mix_q ? mixed : s2_base_q;

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      out_q <= res_d;
    end
  end

  assign valid_o = out_vld_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      result_hi_o[63 - 8 * i -: 8] = out_q[i];
      result_lo_o[63 - 8 * i -: 8] = out_q[8 + i];
    end
  end

  // Every accepted item produces a result once it has passed through the three pipeline registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 valid_o)
    else $error("accepted item did not reach the output after three cycles");

  // A result never appears without a matching item accepted before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 3))
    else $error("result strobe without a matching accepted item");

  // ShiftRows leaves row zero in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(accept && (mode_i == MODE_SHIFT), 3))
      |-> (result_hi_o[63:32] == $past(state_hi_i[63:32], 3)))
    else $error("ShiftRows changed row zero");

  // ShiftRows rotates row two by two bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(accept && (mode_i == MODE_SHIFT), 3))
      |-> (result_lo_o[63:32] == {$past(state_lo_i[47:32], 3), $past(state_lo_i[63:48], 3)}))
    else $error("ShiftRows row two is not a full rotation by two");

endmodule

[design/art_mix_col.sv]
// One MixColumns column, combining each byte with its precomputed doubled value.
module art_mix_col (
  input  art_pkg::column_t a_i,
  input  art_pkg::column_t dbl_i,
  output art_pkg::column_t col_o
);
  import art_pkg::*;

  assign col_o[0] = dbl_i[0] ^ dbl_i[1] ^ a_i[1] ^ a_i[2] ^ a_i[3];
  assign col_o[1] = a_i[0] ^ dbl_i[1] ^ dbl_i[2] ^ a_i[2] ^ a_i[3];
  assign col_o[2] = a_i[0] ^ a_i[1] ^ dbl_i[2] ^ dbl_i[3] ^ a_i[3];
  assign col_o[3] = dbl_i[0] ^ a_i[0] ^ a_i[1] ^ a_i[2] ^ dbl_i[3];

endmodule

[tb/tb_aes_round_transforms.sv]
// Self-checking testbench for the AES round transform block: directed and random states.
`timescale 1ns / 1ps

module tb_aes_round_transforms;
  import art_pkg::*;

  localparam int          PERIOD_NS   = 10;
  localparam int          IDLE_PCT    = 25;
  localparam int          N_RANDOM    = 400;
  localparam int          STALL_LIMIT = 2000;
  localparam int          TAIL_CYCLES = 8;
  localparam logic [7:0]  REDUCE_POLY = 8'h1B;
  localparam logic [7:0]  AFFINE_CONST = 8'h63;

  typedef struct {
    mode_e       mode;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          may_idle;
    bit          drain_first;
  } round_item_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } round_state_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  mode_i;
  logic [63:0] state_hi_i;
  logic [63:0] state_lo_i;
  logic        valid_o;
  logic [63:0] result_hi_o;
  logic [63:0] result_lo_o;

  round_item_t  pending_items[$];
  round_state_t expected_states[$];
  logic [7:0]   fwd_table[256];
  logic [7:0]   inv_table[256];
  int           error_count;
  int           stall_count;

  aes_round_transforms u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .mode_i      (mode_i),
    .state_hi_i  (state_hi_i),
    .state_lo_i  (state_lo_i),
    .valid_o     (valid_o),
    .result_hi_o (result_hi_o),
    .result_lo_o (result_lo_o)
  );

  always begin
    clk_i = 1'b1;
    #(PERIOD_NS / 2);
    clk_i = 1'b0;
    #(PERIOD_NS / 2);
  end

  function automatic logic [7:0] times_two(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] field_product(logic [7:0] a, logic [7:0] b);
    logic [7:0] sum;
    logic [7:0] term;
    sum  = 8'h00;
    term = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        sum = sum ^ term;
      end
      term = times_two(term);
    end
    return sum;
  endfunction

  function automatic logic [7:0] rotate_left(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // The field inverse is taken as x^254, which also sends zero to zero.
  function automatic logic [7:0] field_inverse(logic [7:0] x);
    logic [7:0] acc;
    acc = 8'h01;
    for (int k = 0; k < 254; k++) begin
      acc = field_product(acc, x);
    end
    return acc;
  endfunction

  function automatic round_state_t transform_state(mode_e mode, logic [63:0] hi,
                                                   logic [63:0] lo);
    logic [7:0]   src[16];
    logic [7:0]   dst[16];
    logic [7:0]   a0, a1, a2, a3;
    round_state_t res;
    for (int i = 0; i < 8; i++) begin
      src[i]     = hi[63 - 8 * i -: 8];
      src[8 + i] = lo[63 - 8 * i -: 8];
    end
    case (mode)
      MODE_SUB: begin
        for (int i = 0; i < 16; i++) dst[i] = fwd_table[src[i]];
      end
      MODE_INV_SUB: begin
        for (int i = 0; i < 16; i++) dst[i] = inv_table[src[i]];
      end
      MODE_SHIFT: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) dst[4 * r + c] = src[4 * r + ((c + r) % 4)];
        end
      end
      default: begin
        for (int c = 0; c < 4; c++) begin
          a0 = src[c];
          a1 = src[4 + c];
          a2 = src[8 + c];
          a3 = src[12 + c];
          dst[c]      = times_two(a0) ^ times_two(a1) ^ a1 ^ a2 ^ a3;
          dst[4 + c]  = a0 ^ times_two(a1) ^ times_two(a2) ^ a2 ^ a3;
          dst[8 + c]  = a0 ^ a1 ^ times_two(a2) ^ times_two(a3) ^ a3;
          dst[12 + c] = times_two(a0) ^ a0 ^ a1 ^ a2 ^ times_two(a3);
        end
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      res.hi[63 - 8 * i -: 8] = dst[i];
      res.lo[63 - 8 * i -: 8] = dst[8 + i];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic add_item(mode_e mode, logic [63:0] hi, logic [63:0] lo, bit may_idle,
                          bit drain_first);
    round_item_t it;
    it.mode        = mode;
    it.hi          = hi;
    it.lo          = lo;
    it.may_idle    = may_idle;
    it.drain_first = drain_first;
    pending_items.push_back(it);
  endtask

  // Driver: an item is taken when start_i is high and busy_o is low at a rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic go;
    if (!rst_ni) begin
      start_i    <= 1'b0;
      mode_i     <= MODE_SUB;
      state_hi_i <= '0;
      state_lo_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        expected_states.push_back(transform_state(mode_e'(mode_i), state_hi_i, state_lo_i));
        void'(pending_items.pop_front());
      end
      go = 1'b0;
      if (start_i && busy_o) begin
        go = 1'b1;
      end else if (pending_items.size() > 0) begin
        if (pending_items[0].drain_first && expected_states.size() != 0) begin
          go = 1'b0;
        end else if (pending_items[0].may_idle && $urandom_range(99) < IDLE_PCT) begin
          go = 1'b0;
        end else begin
          go = 1'b1;
        end
      end
      start_i <= go;
      if (go && !(start_i && busy_o)) begin
        mode_i     <= pending_items[0].mode;
        state_hi_i <= pending_items[0].hi;
        state_lo_i <= pending_items[0].lo;
      end
    end
  end

  always @(posedge clk_i) begin : check_proc
    round_state_t want;
    if (rst_ni && valid_o) begin
      if (expected_states.size() == 0) begin
        $error("result_hi: unexpected result %h, result_lo %h", result_hi_o, result_lo_o);
        error_count++;
      end else begin
        want = expected_states.pop_front();
        if (result_hi_o !== want.hi) begin
          $error("result_hi: expected %h, got %h", want.hi, result_hi_o);
          error_count++;
        end
        if (result_lo_o !== want.lo) begin
          $error("result_lo: expected %h, got %h", want.lo, result_lo_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    mode_e m;
    rst_ni      = 1'b0;
    error_count = 0;
    stall_count = 0;

    for (int i = 0; i < 256; i++) begin
      logic [7:0] b;
      b = field_inverse(8'(i));
      fwd_table[i] = b ^ rotate_left(b, 1) ^ rotate_left(b, 2) ^ rotate_left(b, 3)
                     ^ rotate_left(b, 4) ^ AFFINE_CONST;
    end
    for (int i = 0; i < 256; i++) begin
      inv_table[fwd_table[i]] = 8'(i);
    end

    // Directed: all-zero, all-one, byte ramp and alternating patterns in every mode.
    for (int k = 0; k < 4; k++) begin
      m = mode_e'(k);
      add_item(m, 64'h0, 64'h0, 1'b1, 1'b0);
      add_item(m, '1, '1, 1'b1, 1'b0);
      add_item(m, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1, 1'b0);
      add_item(m, 64'haa55aa55_55aa55aa, 64'h55aa55aa_aa55aa55, 1'b1, 1'b0);
    end
    add_item(MODE_INV_SUB, 64'h6363636363636363, 64'h6363636363636363, 1'b1, 1'b0);
    add_item(MODE_SHIFT, 64'h00112233_44556677, 64'h8899aabb_ccddeeff, 1'b0, 1'b0);
    add_item(MODE_MIX, 64'hdbf2010c_13f2010c, 64'h53010101_45300101, 1'b0, 1'b0);
    add_item(MODE_SUB, 64'h80fe7f01_1b36c663, 64'h0263ff00_52097c8d, 1'b0, 1'b0);

    // Random part; the middle stretch skips random idles but still has a drain wait.
    for (int n = 0; n < N_RANDOM; n++) begin
      add_item(mode_e'($urandom_range(3)), rand_word(), rand_word(),
               !(n >= 150 && n < 250), (n % 100) == 0);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || expected_states.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_states.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
